FILE: design/equal_pair_counter_macros.svh
// Assertion macros shared by the equal pair counter checker.
`ifndef EQUAL_PAIR_COUNTER_MACROS_SVH
`define EQUAL_PAIR_COUNTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("equal pair counter: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define EPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("equal pair counter: next-cycle check failed");

`endif

FILE: design/epc_pkg.sv
// Shared constants, types and helpers of the equal pair counter.
package epc_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_BITS  = 32;
    localparam int IN_VALUE_W  = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int TOTAL_W     = 32;
    localparam int OUT_TDATA_W = ((TOTAL_W + 1 + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 2;

    // Bit positions inside the input tuser.
    localparam int TUSER_OP  = 0;
    localparam int TUSER_HAS = 1;

    // Operation codes.
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_PROBE = 1'b1;

    // One probe travelling along the cell row.
    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] value;
        logic                  has;
        logic                  last;
        logic [CNT_W-1:0]      hits;
    } t_probe;

    // Sign-extends the raw element and keeps its low VALUE_BITS bits.
    function automatic logic [VALUE_BITS-1:0] norm_value(input logic [IN_VALUE_W-1:0] raw);
        logic [63:0] ext;
        ext = {{(64 - IN_VALUE_W){raw[IN_VALUE_W-1]}}, raw};
        return ext[VALUE_BITS-1:0];
    endfunction

endpackage

FILE: design/epc_cell.sv
// One compare cell: holds a stored element and one probe pipeline stage.
module epc_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_clear,
    input  logic                           i_shift,
    input  logic [epc_pkg::VALUE_BITS-1:0] i_store_value,
    input  logic                           i_store_valid,
    output logic [epc_pkg::VALUE_BITS-1:0] o_store_value,
    output logic                           o_store_valid,
    input  epc_pkg::t_probe                i_probe,
    output epc_pkg::t_probe                o_probe
);

    logic [epc_pkg::VALUE_BITS-1:0] r_value;
    logic                           r_valid;
    epc_pkg::t_probe                r_probe;
    epc_pkg::t_probe                n_probe;
    logic                           w_hit;

    assign w_hit = r_valid && i_probe.valid && i_probe.has && (r_value == i_probe.value);

    always_comb begin
        n_probe      = i_probe;
        n_probe.hits = i_probe.hits + epc_pkg::CNT_W'(w_hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_store_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_store_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else if (i_en) begin
            r_probe.valid <= n_probe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_probe.value <= n_probe.value;
            r_probe.has   <= n_probe.has;
            r_probe.last  <= n_probe.last;
            r_probe.hits  <= n_probe.hits;
        end
    end

    assign o_store_value = r_value;
    assign o_store_valid = r_valid;
    assign o_probe       = r_probe;

endmodule

FILE: design/equal_pair_counter.sv
// Top level of the equal pair counter: a row of compare cells and the job control.
// A probe that closes the second array passes through every cell of the row and then the output register.
// Throughput: one item per cycle unless held off as below; a probe walks the DEPTH-cell row,
// one cell per cycle. After a job's last probe the input holds off until it leaves the row.
// A stalled output transfer freezes the row and holds off the input.
// Reset (synchronous, active low) empties the cells, clears the job and drops any result.
module equal_pair_counter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [epc_pkg::IN_VALUE_W-1:0]  i_s_tdata,  // [31:0] value
    input  logic [epc_pkg::IN_TUSER_W-1:0]  i_s_tuser,  // [0] operation, [1] has_value
    input  logic                            i_s_tlast,  // last
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [epc_pkg::OUT_TDATA_W-1:0] o_m_tdata   // [31:0] match_count, [32] overflow
);

    // Store chain: element k+1 feeds from cell k; a new element always enters cell 0,
    // so the stored elements pack toward the front of the row.
    logic [epc_pkg::VALUE_BITS-1:0] w_store_value [epc_pkg::DEPTH+1];
    logic                           w_store_valid [epc_pkg::DEPTH+1];
    // Probe chain: stage k is the probe entering cell k; the last stage is the row's tail.
    epc_pkg::t_probe                w_probe       [epc_pkg::DEPTH+1];
    epc_pkg::t_probe                w_probe_in;

    // Job state.
    logic [epc_pkg::CNT_W-1:0]   r_count;
    logic [epc_pkg::TOTAL_W-1:0] r_total;
    logic                        r_dropped;
    logic                        r_closed;
    logic                        r_clear_pend;
    logic [epc_pkg::CNT_W-1:0]   n_count;
    logic [epc_pkg::TOTAL_W-1:0] n_total;
    logic                        n_dropped;
    logic                        n_closed;
    logic                        n_clear_pend;

    // Output register.
    logic                        r_out_valid;
    logic [epc_pkg::TOTAL_W-1:0] r_out_count;
    logic                        r_out_ovf;

    logic                        w_en;
    logic                        w_accept;
    logic                        w_op;
    logic                        w_has;
    logic                        w_shift;
    logic                        w_tail_fire;
    logic                        w_job_end;
    logic [epc_pkg::TOTAL_W:0]   w_sum;
    logic [epc_pkg::TOTAL_W-1:0] w_sat_sum;

    // The whole row advances unless a finished result is still waiting to be taken.
    assign w_en       = !r_out_valid || i_m_tready;
    // While the last probe of a job is in the row, new items wait so the next job
    // never sees the old elements and the old probes never see new ones.
    assign o_s_tready = w_en && !r_clear_pend;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_op       = i_s_tuser[epc_pkg::TUSER_OP];
    assign w_has      = i_s_tuser[epc_pkg::TUSER_HAS];

    // A store shifts the row only when the first array is still open and there is room.
    assign w_shift = w_accept && (w_op == epc_pkg::OP_STORE) && !r_closed && w_has &&
                     (r_count < epc_pkg::CNT_W'(epc_pkg::DEPTH));

    assign w_store_value[0] = epc_pkg::norm_value(i_s_tdata);
    assign w_store_valid[0] = 1'b1;

    always_comb begin
        w_probe_in.valid = w_accept && (w_op == epc_pkg::OP_PROBE);
        w_probe_in.value = epc_pkg::norm_value(i_s_tdata);
        w_probe_in.has   = w_has;
        w_probe_in.last  = i_s_tlast;
        w_probe_in.hits  = '0;
    end

    assign w_probe[0] = w_probe_in;

    // When the closing probe reaches the tail, every older probe has already left,
    // so the cells can be emptied in the same cycle.
    assign w_tail_fire = w_en && w_probe[epc_pkg::DEPTH].valid;
    assign w_job_end   = w_tail_fire && w_probe[epc_pkg::DEPTH].last;

    genvar k;
    generate
        for (k = 0; k < epc_pkg::DEPTH; k++) begin : g_cell
            epc_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_en          (w_en),
                .i_clear       (w_job_end),
                .i_shift       (w_shift),
                .i_store_value (w_store_value[k]),
                .i_store_valid (w_store_valid[k]),
                .o_store_value (w_store_value[k+1]),
                .o_store_valid (w_store_valid[k+1]),
                .i_probe       (w_probe[k]),
                .o_probe       (w_probe[k+1])
            );
        end
    endgenerate

    // Saturating add of the tail probe's hit count into the running total.
    assign w_sum     = {1'b0, r_total} +
                       (epc_pkg::TOTAL_W + 1)'(w_probe[epc_pkg::DEPTH].hits);
    assign w_sat_sum = w_sum[epc_pkg::TOTAL_W] ? '1 : w_sum[epc_pkg::TOTAL_W-1:0];

    always_comb begin
        n_count      = r_count;
        n_total      = r_total;
        n_dropped    = r_dropped;
        n_closed     = r_closed;
        n_clear_pend = r_clear_pend;

        if (w_accept) begin
            if (w_op == epc_pkg::OP_STORE) begin
                // Stores after the first array has closed are ignored, last bit included.
                if (!r_closed) begin
                    if (w_shift) begin
                        n_count = r_count + epc_pkg::CNT_W'(1);
                    end else if (w_has) begin
                        n_dropped = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_closed = 1'b1;
                    end
                end
            end else begin
                // A probe closes the first array implicitly.
                n_closed = 1'b1;
                if (i_s_tlast) begin
                    n_clear_pend = 1'b1;
                end
            end
        end

        if (w_tail_fire) begin
            n_total = w_sat_sum;
        end

        if (w_job_end) begin
            n_count      = '0;
            n_total      = '0;
            n_dropped    = 1'b0;
            n_closed     = 1'b0;
            n_clear_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_total      <= '0;
            r_dropped    <= 1'b0;
            r_closed     <= 1'b0;
            r_clear_pend <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_total      <= n_total;
            r_dropped    <= n_dropped;
            r_closed     <= n_closed;
            r_clear_pend <= n_clear_pend;
        end
    end

    // The output register loads only when it is empty or its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_job_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_job_end) begin
            r_out_count <= w_sat_sum;
            r_out_ovf   <= r_dropped;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(epc_pkg::OUT_TDATA_W - epc_pkg::TOTAL_W - 1){1'b0}},
                         r_out_ovf, r_out_count};

endmodule

FILE: design/epc_checker.sv
// Port-level checker of the equal pair counter and its bind.
`include "equal_pair_counter_macros.svh"

module epc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [epc_pkg::IN_VALUE_W-1:0]  i_s_tdata,
    input logic [epc_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input logic                            i_s_tlast,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [epc_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    logic                                                w_last_probe;
    logic                                                w_out_stall;
    logic [epc_pkg::OUT_TDATA_W-epc_pkg::TOTAL_W-2:0]    w_pad;

    assign w_last_probe = i_s_tvalid && o_s_tready && i_s_tlast &&
                          (i_s_tuser[epc_pkg::TUSER_OP] == epc_pkg::OP_PROBE);
    assign w_out_stall  = o_m_tvalid && !i_m_tready;
    assign w_pad        = o_m_tdata[epc_pkg::OUT_TDATA_W-1:epc_pkg::TOTAL_W+1];

    // A waiting result holds until its transfer.
    `EPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_m_tvalid && $stable(o_m_tdata))
    // The padding above the overflow bit is zero whenever a result is valid.
    `EPC_ASSERT_SAME(a_pad_zero, i_clk, i_rst_n, o_m_tvalid, w_pad == '0)
    // A closing probe holds off the input while it is still in the cell row.
    `EPC_ASSERT_NEXT(a_job_drain, i_clk, i_rst_n, w_last_probe, !o_s_tready)
    // A stalled result freezes the row, so no input transfer can happen.
    `EPC_ASSERT_SAME(a_stall_in, i_clk, i_rst_n, w_out_stall, !o_s_tready)

endmodule

bind equal_pair_counter epc_checker u_epc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
